FILE: hdl/pibb_pkg.sv
// Package for the paged indirect bus bridge: item types, register map codes,
// controller command and datapath status structs, and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package pibb_pkg;

  // Default parameter values.
  localparam int unsigned STORE_WORDS_DEF = 16384;
  localparam int unsigned BRIDGE_PAGE_DEF = 4;

  // Register numbers of the management window.
  localparam logic [4:0] REG_PAGE_SEL = 5'h1f;
  localparam logic [4:0] REG_MODE     = 5'h10;
  localparam logic [4:0] REG_WA_HI    = 5'h11;
  localparam logic [4:0] REG_WA_LO    = 5'h12;
  localparam logic [4:0] REG_WD_HI    = 5'h13;
  localparam logic [4:0] REG_WD_LO    = 5'h14;
  localparam logic [4:0] REG_RA_HI    = 5'h15;
  localparam logic [4:0] REG_RA_LO    = 5'h16;
  localparam logic [4:0] REG_RD_HI    = 5'h17;
  localparam logic [4:0] REG_RD_LO    = 5'h18;

  // Mode register bit that selects auto-increment, and the address step.
  localparam int unsigned MODE_INCR_BIT = 15;
  localparam logic [31:0] ADDR_STEP     = 32'd4;

  // Access codes.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // One register access.
  typedef struct packed {
    logic        action;
    logic [4:0]  reg_addr;
    logic [15:0] reg_data;
  } in_t;

  // One access result.
  typedef struct packed {
    logic [15:0] read_value;
    logic        word_committed;
    logic [31:0] commit_address;
    logic [31:0] commit_word;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic idx_go;
    logic exec;
    logic finish_fetch;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mem_op;
    logic fetch;
    logic idx_done;
  } dp_status_t;

endpackage

FILE: hdl/paged_indirect_bus_bridge.sv
// Top level of the paged indirect bus bridge: controller plus datapath.
// Depends on pibb_pkg, pibb_ctrl and pibb_dp.
//
// Usage: a 16-bit management register access enters on item_i when start_i is
// high and busy_o is low; that edge completes the input transfer. Exactly one
// result follows on result_o, marked by done_o for a single cycle; the
// receiver takes it in that cycle and cannot hold it off.
// A register access or word commit passes through the EXEC state; a fetch (read
// of the high read-data half) adds the FETCH state, which waits on the
// registered read port of the word store. When STORE_WORDS is not a power of
// two, a commit or fetch also passes the INDEX state, where the index unit does
// a reciprocal multiply, a remainder step and one correcting subtract, then
// reports the index.
// busy_o falls in the cycle the result is shown, so the next access may be
// transferred while the result is on the ports.
// Reset clears the page, mode, addresses, pending half and read latch; the word
// store is not cleared and must be written before it is read.
`timescale 1ns / 1ps

module paged_indirect_bus_bridge #(
  parameter int unsigned STORE_WORDS = pibb_pkg::STORE_WORDS_DEF,
  parameter int unsigned BRIDGE_PAGE = pibb_pkg::BRIDGE_PAGE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pibb_pkg::in_t  item_i,
  output logic           busy_o,
  output logic           done_o,
  output pibb_pkg::out_t result_o
);

  import pibb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing of one access.
  pibb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Registers, decode and word store.
  pibb_dp #(
    .STORE_WORDS(STORE_WORDS),
    .BRIDGE_PAGE(BRIDGE_PAGE)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .status_o(status),
    .result_o(result_o)
  );

endmodule

FILE: hdl/pibb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pibb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pibb_index.sv
// Word index unit: maps a byte address to a store index, (address / 4) modulo
// the store depth. Depends on pibb_pkg only through its parent's parameters.
`timescale 1ns / 1ps

module pibb_index #(
  parameter int unsigned STORE_WORDS = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic [31:0]                    addr_i,
  output logic                           done_o,
  output logic [$clog2(STORE_WORDS)-1:0] index_o
);

  localparam int unsigned AW = $clog2(STORE_WORDS);

  if ((STORE_WORDS & (STORE_WORDS - 1)) == 0) begin : g_pow2
    // A power-of-two depth is a plain bit field of the word address.
    assign done_o  = 1'b1;
    assign index_o = addr_i[2 +: AW];
  end else begin : g_reduce
    // Reciprocal reduction: the quotient estimate from a multiply by 2^30 / depth
    // is low by at most one, so one conditional subtract fixes the remainder.
    localparam logic [29:0] NVAL  = 30'(STORE_WORDS);
    localparam logic [26:0] RECIP = 27'((64'd1 << 30) / STORE_WORDS);

    localparam logic [1:0] STEP_QUOT = 2'd0;
    localparam logic [1:0] STEP_REM  = 2'd1;
    localparam logic [1:0] STEP_FIX  = 2'd2;

    logic [29:0] addr_q;
    logic [26:0] quot_q;
    logic [29:0] rem_q;
    logic [1:0]  step_q;
    logic        run_q;
    logic        done_q;
    logic [56:0] quot_full;
    logic [56:0] quot_times_n;

    assign quot_full    = 57'(addr_q) * 57'(RECIP);
    assign quot_times_n = 57'(quot_q) * 57'(NVAL);

    // Three steps: quotient estimate, remainder, correction.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        addr_q <= '0;
        quot_q <= '0;
        rem_q  <= '0;
        step_q <= STEP_QUOT;
        run_q  <= 1'b0;
        done_q <= 1'b0;
      end else if (go_i) begin
        addr_q <= addr_i[31:2];
        step_q <= STEP_QUOT;
        run_q  <= 1'b1;
        done_q <= 1'b0;
      end else if (run_q) begin
        case (step_q)
          STEP_QUOT: begin
            quot_q <= quot_full[56:30];
            step_q <= STEP_REM;
          end
          STEP_REM: begin
            rem_q  <= addr_q - quot_times_n[29:0];
            step_q <= STEP_FIX;
          end
          STEP_FIX: begin
            if (rem_q >= NVAL) begin
              rem_q <= rem_q - NVAL;
            end
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
          default: begin
            step_q <= STEP_QUOT;
          end
        endcase
      end else begin
        done_q <= 1'b0;
      end
    end

    assign done_o  = done_q;
    assign index_o = rem_q[AW-1:0];
  end

endmodule

FILE: hdl/pibb_ctrl.sv
// Controller state machine of the bridge: sequences capture, index, execute
// and fetch steps. Depends on pibb_pkg.
`timescale 1ns / 1ps

module pibb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pibb_pkg::dp_status_t  status_i,
  output pibb_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  import pibb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;
  localparam logic [1:0] ST_FETCH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  // Next state and command decode.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.mem_op && !status_i.idx_done) begin
          cmd_o.idx_go = 1'b1;
          state_d      = ST_INDEX;
        end else begin
          cmd_o.exec = 1'b1;
          if (status_i.fetch) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      ST_INDEX: begin
        if (status_i.idx_done) begin
          cmd_o.exec = 1'b1;
          if (status_i.fetch) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.finish_fetch = 1'b1;
        state_d            = ST_IDLE;
        done_d             = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result strobe registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;

endmodule

FILE: hdl/pibb_dp.sv
// Datapath of the bridge: bridge registers, decode, index unit and word store.
// Depends on pibb_pkg, pibb_index and pibb_ram.
`timescale 1ns / 1ps

module pibb_dp #(
  parameter int unsigned STORE_WORDS = pibb_pkg::STORE_WORDS_DEF,
  parameter int unsigned BRIDGE_PAGE = pibb_pkg::BRIDGE_PAGE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pibb_pkg::in_t        item_i,
  input  pibb_pkg::ctrl_cmd_t  cmd_i,
  output pibb_pkg::dp_status_t status_o,
  output pibb_pkg::out_t       result_o
);

  import pibb_pkg::*;

  localparam int unsigned AW = $clog2(STORE_WORDS);

  in_t         item_q, item_d;
  out_t        res_q, res_d;
  logic [15:0] page_q, page_d;
  logic        incr_q, incr_d;
  logic [31:0] wa_q, wa_d;
  logic [31:0] ra_q, ra_d;
  logic [15:0] hi_q, hi_d;
  logic [31:0] latch_q, latch_d;

  logic          is_page;
  logic          bridge;
  logic          is_write;
  logic          is_commit;
  logic          is_fetch;
  logic [31:0]   idx_addr;
  logic          idx_done;
  logic [AW-1:0] idx;
  logic [31:0]   rdata;

  // Decode of the captured access.
  assign is_write  = item_q.action == ACT_WRITE;
  assign is_page   = item_q.reg_addr == REG_PAGE_SEL;
  assign bridge    = page_q == 16'(BRIDGE_PAGE);
  assign is_commit = bridge && is_write && (item_q.reg_addr == REG_WD_LO);
  assign is_fetch  = bridge && !is_write && (item_q.reg_addr == REG_RD_HI);
  assign idx_addr  = is_fetch ? ra_q : wa_q;

  assign status_o.mem_op   = is_commit || is_fetch;
  assign status_o.fetch    = is_fetch;
  assign status_o.idx_done = idx_done;

  // Store index of the address used by this access.
  pibb_index #(
    .STORE_WORDS(STORE_WORDS)
  ) u_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.idx_go),
    .addr_i (idx_addr),
    .done_o (idx_done),
    .index_o(idx)
  );

  // Word store standing in for the bus target.
  pibb_ram #(
    .WIDTH(32),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && is_commit),
    .waddr_i(idx),
    .wdata_i({hi_q, item_q.reg_data}),
    .re_i   (cmd_i.exec && is_fetch),
    .raddr_i(idx),
    .rdata_o(rdata)
  );

  // Register updates and result of one access.
  always_comb begin
    item_d  = item_q;
    res_d   = res_q;
    page_d  = page_q;
    incr_d  = incr_q;
    wa_d    = wa_q;
    ra_d    = ra_q;
    hi_d    = hi_q;
    latch_d = latch_q;
    if (cmd_i.capture) begin
      item_d = item_i;
    end
    if (cmd_i.exec) begin
      res_d = '0;
      if (is_page) begin
        if (is_write) begin
          page_d = item_q.reg_data;
        end else begin
          res_d.read_value = page_q;
        end
      end else if (bridge && is_write) begin
        case (item_q.reg_addr)
          REG_MODE:  incr_d = item_q.reg_data[MODE_INCR_BIT];
          REG_WA_HI: wa_d = {item_q.reg_data, wa_q[15:0]};
          REG_WA_LO: wa_d = {wa_q[31:16], item_q.reg_data};
          REG_WD_HI: hi_d = item_q.reg_data;
          REG_WD_LO: begin
            res_d.word_committed = 1'b1;
            res_d.commit_address = wa_q;
            res_d.commit_word    = {hi_q, item_q.reg_data};
            if (incr_q) begin
              wa_d = wa_q + ADDR_STEP;
            end
          end
          REG_RA_HI: ra_d = {item_q.reg_data, ra_q[15:0]};
          REG_RA_LO: ra_d = {ra_q[31:16], item_q.reg_data};
          default: ;
        endcase
      end else if (bridge) begin
        case (item_q.reg_addr)
          REG_MODE:  res_d.read_value = {incr_q, 15'd0};
          REG_WA_HI: res_d.read_value = wa_q[31:16];
          REG_WA_LO: res_d.read_value = wa_q[15:0];
          REG_WD_HI: res_d.read_value = hi_q;
          REG_RA_HI: res_d.read_value = ra_q[31:16];
          REG_RA_LO: res_d.read_value = ra_q[15:0];
          REG_RD_LO: begin
            res_d.read_value = latch_q[15:0];
            if (incr_q) begin
              ra_d = ra_q + ADDR_STEP;
            end
          end
          default: ;
        endcase
      end
    end
    // The fetched word arrives in the cycle after the store read.
    if (cmd_i.finish_fetch) begin
      latch_d          = rdata;
      res_d.read_value = rdata[31:16];
    end
  end

  // Bridge state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      incr_q  <= 1'b0;
      wa_q    <= '0;
      ra_q    <= '0;
      hi_q    <= '0;
      latch_q <= '0;
    end else begin
      page_q  <= page_d;
      incr_q  <= incr_d;
      wa_q    <= wa_d;
      ra_q    <= ra_d;
      hi_q    <= hi_d;
      latch_q <= latch_d;
    end
  end

  // Captured access and result payload.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign result_o = res_q;

endmodule

FILE: dv/pibb_checker.sv
// Result checker for the paged indirect bus bridge: watches the access and result
// transfers, keeps its own copy of the bridge state and compares every result.
// Depends on pibb_pkg.
`timescale 1ns / 1ps

module pibb_checker #(
  parameter int unsigned STORE_WORDS = pibb_pkg::STORE_WORDS_DEF,
  parameter int unsigned BRIDGE_PAGE = pibb_pkg::BRIDGE_PAGE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  pibb_pkg::in_t  item_i,
  input  logic           busy_i,
  input  logic           done_i,
  input  pibb_pkg::out_t result_i,
  output int unsigned    fails_o,
  output int unsigned    pending_o
);

  import pibb_pkg::*;

  // Bridge state as the window exposes it.
  logic [15:0] page_q;
  logic        incr_q;
  logic [31:0] wr_addr_q;
  logic [31:0] rd_addr_q;
  logic [15:0] wd_high_q;
  logic [31:0] rd_latch_q;
  logic [31:0] word_mem [STORE_WORDS];

  // Results owed by the bridge, oldest first.
  out_t        due_results[$];
  int unsigned fail_cnt = 0;

  assign fails_o = fail_cnt;

  // Applies one register access to the state and returns the result it owes.
  function automatic out_t bridge_access(input in_t acc);
    out_t res;
    res = '0;
    if (acc.reg_addr == REG_PAGE_SEL) begin
      if (acc.action == ACT_WRITE) page_q = acc.reg_data;
      else res.read_value = page_q;
    end else if (page_q == 16'(BRIDGE_PAGE)) begin
      if (acc.action == ACT_WRITE) begin
        case (acc.reg_addr)
          REG_MODE:  incr_q = acc.reg_data[MODE_INCR_BIT];
          REG_WA_HI: wr_addr_q[31:16] = acc.reg_data;
          REG_WA_LO: wr_addr_q[15:0] = acc.reg_data;
          REG_WD_HI: wd_high_q = acc.reg_data;
          REG_WD_LO: begin
            res.word_committed = 1'b1;
            res.commit_address = wr_addr_q;
            res.commit_word    = {wd_high_q, acc.reg_data};
            word_mem[(wr_addr_q >> 2) % STORE_WORDS] = res.commit_word;
            if (incr_q) wr_addr_q = wr_addr_q + ADDR_STEP;
          end
          REG_RA_HI: rd_addr_q[31:16] = acc.reg_data;
          REG_RA_LO: rd_addr_q[15:0] = acc.reg_data;
          default: ;
        endcase
      end else begin
        case (acc.reg_addr)
          REG_MODE:  res.read_value = {incr_q, 15'd0};
          REG_WA_HI: res.read_value = wr_addr_q[31:16];
          REG_WA_LO: res.read_value = wr_addr_q[15:0];
          REG_WD_HI: res.read_value = wd_high_q;
          REG_RA_HI: res.read_value = rd_addr_q[31:16];
          REG_RA_LO: res.read_value = rd_addr_q[15:0];
          REG_RD_HI: begin
            rd_latch_q     = word_mem[(rd_addr_q >> 2) % STORE_WORDS];
            res.read_value = rd_latch_q[31:16];
          end
          REG_RD_LO: begin
            res.read_value = rd_latch_q[15:0];
            if (incr_q) rd_addr_q = rd_addr_q + ADDR_STEP;
          end
          default: ;
        endcase
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Compare a result transfer first, then predict for an access taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      page_q     = '0;
      incr_q     = 1'b0;
      wr_addr_q  = '0;
      rd_addr_q  = '0;
      wd_high_q  = '0;
      rd_latch_q = '0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no access outstanding");
          fail_cnt++;
        end else begin
          want = due_results.pop_front();
          check_field("read_value", 32'(want.read_value), 32'(result_i.read_value));
          check_field("word_committed", 32'(want.word_committed),
                      32'(result_i.word_committed));
          check_field("commit_address", want.commit_address, result_i.commit_address);
          check_field("commit_word", want.commit_word, result_i.commit_word);
        end
      end
      if (start_i && !busy_i) due_results.push_back(bridge_access(item_i));
      pending_o <= due_results.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Top of the bridge testbench: clock, reset and register access stimulus.
// Depends on pibb_pkg, paged_indirect_bus_bridge and pibb_checker.
`timescale 1ns / 1ps

module testbench;

  import pibb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RANDOM_ACCESSES = 1950;
  // Registers that the bridge page leaves unmapped.
  localparam logic [4:0]  REG_UNMAPPED_LO = 5'h00;
  localparam logic [4:0]  REG_UNMAPPED_HI = 5'h19;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  in_t         item_i  = '0;
  logic        busy_o;
  logic        done_o;
  out_t        result_o;
  int unsigned fails;
  int unsigned pending;

  // Stimulus-side view of the bridge, used only to keep fetches on written words.
  logic [15:0] sh_page = '0;
  logic        sh_incr = 1'b0;
  logic [31:0] sh_wa   = '0;
  logic [31:0] sh_ra   = '0;
  bit          written [STORE_WORDS_DEF];
  logic [15:0] wr_lo_history[$];

  int unsigned idle_pct = 0;
  int unsigned sent     = 0;
  int unsigned cycles   = 0;

  always #6 clk_i = ~clk_i;

  paged_indirect_bus_bridge i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  pibb_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .item_i    (item_i),
    .busy_i    (busy_o),
    .done_i    (done_o),
    .result_i  (result_o),
    .fails_o   (fails),
    .pending_o (pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("paged_indirect_bus_bridge test failed");
      $finish;
    end
  end

  // Performs one access transfer. A fetch of a never-written word becomes a
  // harmless address readback instead.
  task automatic send(input logic act, input logic [4:0] reg_num, input logic [15:0] data);
    in_t acc;
    bit  on_bridge;
    acc       = '{action: act, reg_addr: reg_num, reg_data: data};
    on_bridge = (sh_page == 16'(BRIDGE_PAGE_DEF));
    if (on_bridge && act == ACT_READ && reg_num == REG_RD_HI &&
        !written[(sh_ra >> 2) % STORE_WORDS_DEF]) begin
      acc.reg_addr = REG_RA_LO;
    end
    if (acc.reg_addr == REG_PAGE_SEL) begin
      if (act == ACT_WRITE) sh_page = data;
    end else if (on_bridge && act == ACT_WRITE) begin
      case (acc.reg_addr)
        REG_MODE:  sh_incr = data[MODE_INCR_BIT];
        REG_WA_HI: sh_wa[31:16] = data;
        REG_WA_LO: sh_wa[15:0] = data;
        REG_WD_LO: begin
          written[(sh_wa >> 2) % STORE_WORDS_DEF] = 1'b1;
          if (sh_incr) sh_wa = sh_wa + ADDR_STEP;
        end
        REG_RA_HI: sh_ra[31:16] = data;
        REG_RA_LO: sh_ra[15:0] = data;
        default: ;
      endcase
    end else if (on_bridge && acc.reg_addr == REG_RD_LO && sh_incr) begin
      sh_ra = sh_ra + ADDR_STEP;
    end
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= acc;
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  // Holds off new accesses until every outstanding result has arrived.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [15:0] addr_high_half();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // One random sequence: mostly well-formed word bursts, the rest noise.
  task automatic random_sequence();
    int unsigned kind;
    int unsigned n;
    logic [15:0] lo;
    kind = $urandom_range(99);
    n    = $urandom_range(6, 1);
    if (kind < 55 && sh_page != 16'(BRIDGE_PAGE_DEF)) begin
      send(ACT_WRITE, REG_PAGE_SEL, 16'(BRIDGE_PAGE_DEF));
    end
    if (kind < 30) begin
      // Write burst: set the address, then commit a few words.
      if ($urandom_range(3) == 0) send(ACT_WRITE, REG_MODE, 16'($urandom));
      send(ACT_WRITE, REG_WA_HI, addr_high_half());
      lo = 16'($urandom);
      wr_lo_history.push_back(lo);
      if (wr_lo_history.size() > 16) void'(wr_lo_history.pop_front());
      send(ACT_WRITE, REG_WA_LO, lo);
      repeat (n) begin
        if ($urandom_range(4) != 0) send(ACT_WRITE, REG_WD_HI, 16'($urandom));
        send(ACT_WRITE, REG_WD_LO, 16'($urandom));
      end
    end else if (kind < 55) begin
      // Read burst, mostly reusing the low address half of an earlier write burst.
      if ($urandom_range(5) == 0) send(ACT_WRITE, REG_MODE, 16'($urandom));
      send(ACT_WRITE, REG_RA_HI, addr_high_half());
      if (wr_lo_history.size() != 0 && $urandom_range(7) != 0) begin
        lo = wr_lo_history[$urandom_range(wr_lo_history.size() - 1)];
      end else begin
        lo = 16'($urandom);
      end
      send(ACT_WRITE, REG_RA_LO, lo);
      repeat (n) begin
        if ($urandom_range(5) != 0) send(ACT_READ, REG_RD_HI, 16'($urandom));
        send(ACT_READ, REG_RD_LO, 16'($urandom));
      end
    end else if (kind < 75) begin
      send(ACT_READ, 5'($urandom_range(REG_RD_LO, REG_MODE)), 16'($urandom));
    end else if (kind < 95) begin
      send(1'($urandom), 5'($urandom), 16'($urandom));
    end else begin
      case ($urandom_range(3))
        0:       send(ACT_WRITE, REG_PAGE_SEL, 16'hffff);
        1:       send(ACT_WRITE, REG_PAGE_SEL, 16'($urandom));
        default: send(ACT_WRITE, REG_PAGE_SEL, 16'(BRIDGE_PAGE_DEF));
      endcase
    end
  endtask

  initial begin
    int unsigned base;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed accesses: page select, off-page window, every bridge register,
    // address wrap at the top of the space and writes to the read-data registers.
    send(ACT_READ,  REG_PAGE_SEL, 16'hffff);
    send(ACT_WRITE, REG_MODE,     16'hffff);
    send(ACT_READ,  REG_MODE,     16'h0000);
    send(ACT_WRITE, REG_PAGE_SEL, 16'hffff);
    send(ACT_READ,  REG_PAGE_SEL, 16'h0000);
    send(ACT_WRITE, REG_PAGE_SEL, 16'(BRIDGE_PAGE_DEF));
    send(ACT_WRITE, REG_MODE,     16'h8000);
    send(ACT_READ,  REG_MODE,     16'h0000);
    send(ACT_WRITE, REG_WA_HI,    16'hffff);
    send(ACT_WRITE, REG_WA_LO,    16'hfffe);
    send(ACT_WRITE, REG_WD_HI,    16'hffff);
    send(ACT_READ,  REG_WD_HI,    16'h0000);
    send(ACT_WRITE, REG_WD_LO,    16'hffff);
    send(ACT_READ,  REG_WA_LO,    16'h0000);
    send(ACT_WRITE, REG_WD_HI,    16'h0000);
    send(ACT_WRITE, REG_WD_LO,    16'h0000);
    send(ACT_READ,  REG_WD_LO,    16'hffff);
    send(ACT_WRITE, REG_RA_HI,    16'hffff);
    send(ACT_WRITE, REG_RA_LO,    16'hfffd);
    send(ACT_READ,  REG_RA_HI,    16'h0000);
    send(ACT_READ,  REG_RD_HI,    16'h0000);
    send(ACT_READ,  REG_RD_LO,    16'h0000);
    send(ACT_WRITE, REG_RD_HI,    16'h1234);
    send(ACT_WRITE, REG_RD_LO,    16'h5678);
    send(ACT_READ,  REG_RD_HI,    16'h0000);
    send(ACT_WRITE, REG_MODE,     16'h7fff);
    send(ACT_READ,  REG_RD_LO,    16'h0000);
    send(ACT_READ,  REG_UNMAPPED_LO, 16'h0000);
    send(ACT_WRITE, REG_UNMAPPED_HI, 16'hffff);
    drain();

    // Random accesses in three idling phases, each ending with a full drain.
    base = sent;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 18 : (phase == 1) ? 57 : 0;
      while (sent < base + (phase + 1) * RANDOM_ACCESSES / 3) random_sequence();
      drain();
    end

    repeat (6) @(posedge clk_i);
    if (fails == 0) begin
      $display("paged_indirect_bus_bridge test passed");
    end else begin
      $display("paged_indirect_bus_bridge test failed");
    end
    $finish;
  end

endmodule
